// ===== rtl/sa56_pkg.sv =====
// Package with SHA-256 round constants, types and round functions for the a56 check.
`timescale 1ns / 1ps
package sa56_pkg;

    localparam int ROUNDS = 57;
    localparam int WORDS  = 16;

    localparam logic REG_KERNEL_BIT = 1'b0;
    localparam logic REG_FILL_WORD  = 1'b1;

    localparam logic [4:0]  KERNEL_BIT_RESET = 5'd10;
    localparam logic [31:0] FILL_WORD_RESET  = 32'hFFFFFFFF;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];
    typedef t_word t_win [WORDS];

    localparam t_state INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // One compression round on the working registers a..h.
    function automatic t_state sha_round(input t_state v, input t_word k, input t_word w);
        t_state r;
        t_word  ch;
        t_word  mj;
        t_word  t1;
        t_word  t2;
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + big_s1(v[4]) + ch + k + w;
        t2 = big_s0(v[0]) + mj;
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        return r;
    endfunction

    // Slides the schedule window by one word and appends the next schedule word.
    function automatic t_win win_shift(input t_win w);
        t_win r;
        for (int j = 0; j < WORDS - 1; j++) begin
            r[j] = w[j + 1];
        end
        r[WORDS - 1] = small_s1(w[14]) + w[9] + small_s0(w[1]) + w[0];
        return r;
    endfunction

endpackage

// ===== rtl/sha256_a56_collision_check.sv =====
// Top level: pipelined reduced-round SHA-256 difference check, one candidate per cycle.
//
//  channel  | ports                                              | transfer
//  ---------+----------------------------------------------------+------------------------
//  command  | i_start, o_busy, i_candidate                       | i_start && !o_busy
//  result   | o_valid, o_candidate_echo, o_reg_a_first,          | o_valid (one cycle)
//           | o_reg_a_second, o_match                            |
//  config   | i_cfg_we, i_cfg_addr, i_cfg_wdata                  | i_cfg_we
//
// One round of both blocks per stage. The first round stage loads at the transfer edge,
// then ROUNDS - 1 more round stages and the output register follow.
// A new candidate is taken in every cycle; o_busy stays low.
// Reset clears the valid bits and loads the register reset values.
// The result side has no back-pressure, so the pipeline never stalls.
`timescale 1ns / 1ps
module sha256_a56_collision_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_candidate,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_candidate_echo,
    output logic [31:0] o_reg_a_first,
    output logic [31:0] o_reg_a_second,
    output logic        o_match
);

    localparam int NR = sa56_pkg::ROUNDS;

    logic [4:0]  r_kernel_bit;
    logic [31:0] r_fill_word;

    logic [NR-1:0]   r_vld;
    logic [31:0]     r_cand [NR];
    sa56_pkg::t_state r_st1 [NR];
    sa56_pkg::t_state r_st2 [NR];
    sa56_pkg::t_win   r_win1 [NR];
    sa56_pkg::t_win   r_win2 [NR];

    sa56_pkg::t_win blk1;
    sa56_pkg::t_win blk2;
    logic [31:0]    diff;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_bit <= sa56_pkg::KERNEL_BIT_RESET;
            r_fill_word  <= sa56_pkg::FILL_WORD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sa56_pkg::REG_KERNEL_BIT: r_kernel_bit <= i_cfg_wdata[4:0];
                sa56_pkg::REG_FILL_WORD:  r_fill_word  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Block one differs from the fill only in word 0; block two differs in words 0 and 9.
    always_comb begin
        diff = 32'd1 << r_kernel_bit;
        for (int j = 0; j < sa56_pkg::WORDS; j++) begin
            blk1[j] = r_fill_word;
            blk2[j] = r_fill_word;
        end
        blk1[0] = i_candidate;
        blk2[0] = i_candidate ^ diff;
        blk2[9] = r_fill_word ^ diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NR-2:0], i_start};
        end
    end

    for (genvar s = 0; s < NR; s++) begin : g_round
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_cand[s] <= i_candidate;
                r_st1[s]  <= sa56_pkg::sha_round(sa56_pkg::INIT_HASH,
                                 sa56_pkg::round_k(6'(s)), blk1[0]);
                r_st2[s]  <= sa56_pkg::sha_round(sa56_pkg::INIT_HASH,
                                 sa56_pkg::round_k(6'(s)), blk2[0]);
                r_win1[s] <= sa56_pkg::win_shift(blk1);
                r_win2[s] <= sa56_pkg::win_shift(blk2);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_cand[s] <= r_cand[s-1];
                r_st1[s]  <= sa56_pkg::sha_round(r_st1[s-1],
                                 sa56_pkg::round_k(6'(s)), r_win1[s-1][0]);
                r_st2[s]  <= sa56_pkg::sha_round(r_st2[s-1],
                                 sa56_pkg::round_k(6'(s)), r_win2[s-1][0]);
                r_win1[s] <= sa56_pkg::win_shift(r_win1[s-1]);
                r_win2[s] <= sa56_pkg::win_shift(r_win2[s-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[NR-1];
        end
        o_candidate_echo <= r_cand[NR-1];
        o_reg_a_first    <= r_st1[NR-1][0];
        o_reg_a_second   <= r_st2[NR-1][0];
        o_match          <= (r_st1[NR-1][0] == r_st2[NR-1][0]);
    end

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_vld[0])
        else $error("accepted candidate did not enter the pipeline");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[NR-1]))
        else $error("result strobe without a finished candidate");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match == (o_reg_a_first == o_reg_a_second)))
        else $error("match flag disagrees with register a values");

endmodule
